// ===== design/discounted_return_normalizer_top_defines.svh =====
// Assertion macros for the discounted return normalizer.
`ifndef DISCOUNTED_RETURN_NORMALIZER_TOP_DEFINES_SVH
`define DISCOUNTED_RETURN_NORMALIZER_TOP_DEFINES_SVH
// Check that an implication holds on every clock edge outside reset.
`define DRN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define DRN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/drn_pkg.sv =====
// Shared types and constants for the discounted return normalizer.
package drn_pkg;
    localparam int unsigned EpisodeDepthDefault = 64;
    localparam int unsigned MaxDepth = 64;
    localparam int unsigned CountWidth = 7;
    localparam int unsigned AddrWidth = 6;
    localparam logic [16:0] GammaReset = 17'd64881;
    localparam logic [16:0] GammaOne = 17'd65536;
    localparam logic signed [47:0] GMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] GMin = -48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] reward;
        logic               last_reward;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] normalized_return;
        logic               last_return;
    } out_word_t;
endpackage

// ===== design/discounted_return_normalizer_top.sv =====
// Discounted return normalizer: episode store, return pass, statistics, output.
// Rewards are taken one per cycle (start while busy is low) and stored up to
// EPISODE_DEPTH entries; later rewards are dropped. A last mark closes the
// episode and raises busy. The block then walks the return memory backwards
// (per step a memory read with the discount multiply, then the add and write),
// sums forward, accumulates squared deviations in four 16-bit slices, divides
// the mean and the variance with a 128-bit bit-serial divider, takes a 52-step
// bit-serial square root, and emits one result per step after a 128-bit serial
// divide, with out_valid high for one cycle each. Busy falls with the last
// result of the episode.
// The receiver cannot stall: each result word is shown exactly one cycle.
`include "discounted_return_normalizer_top_defines.svh"
module discounted_return_normalizer_top #(
    parameter int unsigned EPISODE_DEPTH = drn_pkg::EpisodeDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  drn_pkg::in_word_t  in_data,
    output logic               out_valid,
    output drn_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_data
);
    localparam int unsigned AW = drn_pkg::AddrWidth;
    localparam int unsigned CW = drn_pkg::CountWidth;

    typedef enum logic [4:0] {
        S_IDLE, S_RET_RD, S_RET_MUL, S_SUM_RD, S_SUM_ACC, S_MEAN, S_MEAN_W,
        S_VAR_RD, S_VAR_MUL, S_VAR_ACC, S_VDIV, S_VDIV_W, S_SQ_MUL, S_SQ_CMP,
        S_OUT_RD, S_OUT_DIV, S_OUT_W, S_OUT_EMIT
    } state_t;

    state_t               state_reg;
    logic [16:0]          gamma_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        n_reg;
    logic [AW-1:0]        idx_reg;
    logic signed [47:0]   g_reg;
    logic signed [55:0]   sum_reg;
    logic signed [47:0]   mean_reg;
    logic [127:0]         sq_acc_reg;
    logic [127:0]         var_reg;
    logic [51:0]          root_reg;
    logic [103:0]         root_sq_reg;
    logic [5:0]           bit_reg;
    logic [103:0]         prod_reg;
    logic [65:0]          prod_g_reg;
    logic                 neg_reg;
    logic [63:0]          denom_reg;
    logic [48:0]          dmag_reg;
    logic [1:0]           part_reg;
    logic                 out_valid_reg;
    drn_pkg::out_word_t   out_reg;

    // Memory ports
    logic                 rew_we;
    logic [AW-1:0]        rew_raddr;
    logic signed [31:0]   rew_rdata;
    logic                 ret_we;
    logic [AW-1:0]        ret_raddr;
    logic signed [47:0]   ret_rdata;
    logic signed [47:0]   g_new;

    // Divider port
    logic                 div_start;
    logic [127:0]         div_num;
    logic [63:0]          div_den;
    logic                 div_done;
    logic [127:0]         div_quot;
    logic [63:0]          div_rem;

    logic                 accept;
    logic signed [49:0]   g_sum;
    logic [47:0]          g_mag;
    logic signed [48:0]   dev;
    logic [48:0]          dev_mag;
    logic [51:0]          cand;
    logic [103:0]         cand_sq;
    logic [15:0]          var_chunk;
    logic [64:0]          part_prod;
    logic [55:0]          sum_mag;
    logic [31:0]          q_sat;
    logic [63:0]          q_round;

    assign accept = start && !busy;
    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign rew_we = accept && (count_reg < CW'(EPISODE_DEPTH));
    assign rew_raddr = idx_reg;
    assign ret_raddr = idx_reg;
    assign ret_we = (state_reg == S_RET_MUL);

    // Add discounted return to reward, saturate to 48 bits
    always_comb
    begin
        logic [47:0] pm;
        pm = 48'(prod_g_reg[65:16]);
        if (gamma_reg >= drn_pkg::GammaOne)
        begin
            g_sum = 50'(g_reg) + 50'(rew_rdata);
        end
        else if (neg_reg)
        begin
            g_sum = 50'(rew_rdata) - $signed({2'b00, pm});
        end
        else
        begin
            g_sum = 50'(rew_rdata) + $signed({2'b00, pm});
        end
        if (g_sum > 50'(drn_pkg::GMax))
        begin
            g_new = drn_pkg::GMax;
        end
        else if (g_sum < 50'(drn_pkg::GMin))
        begin
            g_new = drn_pkg::GMin;
        end
        else
        begin
            g_new = 48'(g_sum);
        end
    end

    assign g_mag   = g_reg[47] ? 48'(-g_reg) : 48'(g_reg);
    assign dev     = 49'(ret_rdata) - 49'(mean_reg);
    assign dev_mag = dev[48] ? 49'(-dev) : 49'(dev);
    assign cand    = root_reg | (52'd1 << bit_reg);
    assign sum_mag = sum_reg[55] ? 56'(-sum_reg) : 56'(sum_reg);

    // Square of the candidate from the accepted root: r^2 + 2*r*2^b + 2^(2b)
    assign cand_sq = root_sq_reg + (104'(root_reg) << (7'(bit_reg) + 7'd1)) +
                     (104'd1 << {bit_reg, 1'b0});

    // One 16-bit slice of the deviation magnitude times the whole magnitude
    assign var_chunk = 16'(64'(dmag_reg) >> {part_reg, 4'd0});
    assign part_prod = 65'(dmag_reg) * 65'(var_chunk);

    // Round half away from zero on 16 fraction bits of d / denom
    assign q_round = (|div_quot[127:33]) ? 64'h1_0000_0000 :
                     64'(div_quot[32:0]) +
                     64'(({div_rem, 1'b0} >= {1'b0, denom_reg}) ? 1 : 0);
    assign q_sat = neg_reg ?
        ((q_round > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q_round)) :
        ((q_round > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q_round));

    // Divider operand selection
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 64'(n_reg);
        case (state_reg)
            S_MEAN:
            begin
                div_start = 1'b1;
                div_num   = 128'(sum_mag) + 128'(n_reg >> 1);
            end
            S_VDIV:
            begin
                div_start = 1'b1;
                div_num   = sq_acc_reg;
            end
            S_OUT_DIV:
            begin
                div_start = 1'b1;
                div_num   = {63'd0, dmag_reg, 16'd0};
                div_den   = denom_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    drn_store u_store (
        .clk       (clk),
        .rew_we    (rew_we),
        .rew_waddr (count_reg[AW-1:0]),
        .rew_wdata (in_data.reward),
        .rew_raddr (rew_raddr),
        .rew_rdata (rew_rdata),
        .ret_we    (ret_we),
        .ret_waddr (idx_reg),
        .ret_wdata (g_new),
        .ret_raddr (ret_raddr),
        .ret_rdata (ret_rdata)
    );

    drn_divider #(.NumWidth(128), .DenWidth(64)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // Sequencer: store rewards, then the passes over the return memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gamma_reg     <= drn_pkg::GammaReset;
            count_reg     <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        gamma_reg <= (cfg_data > drn_pkg::GammaOne) ?
                                     drn_pkg::GammaOne : cfg_data;
                    end
                    if (accept)
                    begin
                        logic [CW-1:0] nc;
                        nc = rew_we ? count_reg + 1'b1 : count_reg;
                        count_reg <= in_data.last_reward ? '0 : nc;
                        if (in_data.last_reward && (nc != '0))
                        begin
                            n_reg     <= nc;
                            idx_reg   <= AW'(nc - 1'b1);
                            g_reg     <= '0;
                            state_reg <= S_RET_RD;
                        end
                    end
                end
                S_RET_RD:
                begin
                    prod_g_reg <= 66'(g_mag) * 66'(gamma_reg) + 66'd32768;
                    neg_reg    <= g_reg[47];
                    state_reg  <= S_RET_MUL;
                end
                S_RET_MUL:
                begin
                    // rew_rdata is valid now; reuse it as the reward
                    g_reg <= g_new;
                    if (idx_reg == '0)
                    begin
                        sum_reg   <= '0;
                        state_reg <= S_SUM_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_RET_RD;
                    end
                end
                S_SUM_RD:
                begin
                    state_reg <= S_SUM_ACC;
                end
                S_SUM_ACC:
                begin
                    sum_reg <= sum_reg + 56'(ret_rdata);
                    if (idx_reg == AW'(n_reg - 1'b1))
                    begin
                        state_reg <= S_MEAN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SUM_RD;
                    end
                end
                S_MEAN:
                begin
                    neg_reg   <= sum_reg[55];
                    state_reg <= S_MEAN_W;
                end
                S_MEAN_W:
                begin
                    if (div_done)
                    begin
                        mean_reg   <= neg_reg ? 48'(-div_quot[47:0]) : div_quot[47:0];
                        idx_reg    <= '0;
                        sq_acc_reg <= '0;
                        state_reg  <= S_VAR_RD;
                    end
                end
                S_VAR_RD:
                begin
                    state_reg <= S_VAR_MUL;
                end
                S_VAR_MUL:
                begin
                    dmag_reg  <= dev_mag;
                    part_reg  <= '0;
                    state_reg <= S_VAR_ACC;
                end
                S_VAR_ACC:
                begin
                    // Accumulate one slice product per cycle
                    sq_acc_reg <= sq_acc_reg + (128'(part_prod) << {part_reg, 4'd0});
                    if (part_reg != 2'd3)
                    begin
                        part_reg <= part_reg + 1'b1;
                    end
                    else if (idx_reg == AW'(n_reg - 1'b1))
                    begin
                        state_reg <= S_VDIV;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_VAR_RD;
                    end
                end
                S_VDIV:
                begin
                    state_reg <= S_VDIV_W;
                end
                S_VDIV_W:
                begin
                    if (div_done)
                    begin
                        var_reg     <= div_quot;
                        root_reg    <= '0;
                        root_sq_reg <= '0;
                        bit_reg     <= 6'd51;
                        state_reg   <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL:
                begin
                    prod_reg  <= cand_sq;
                    state_reg <= S_SQ_CMP;
                end
                S_SQ_CMP:
                begin
                    if (128'(prod_reg) <= var_reg)
                    begin
                        root_reg    <= cand;
                        root_sq_reg <= prod_reg;
                    end
                    if (bit_reg == '0)
                    begin
                        denom_reg <= 64'((128'(prod_reg) <= var_reg) ? cand : root_reg)
                                     + 64'd1;
                        idx_reg   <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_EMIT;
                end
                S_OUT_EMIT:
                begin
                    dmag_reg  <= dev_mag;
                    neg_reg   <= dev[48];
                    state_reg <= S_OUT_DIV;
                end
                S_OUT_DIV:
                begin
                    state_reg <= S_OUT_W;
                end
                S_OUT_W:
                begin
                    if (div_done)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.normalized_return <= q_sat;
                        out_reg.last_return <= (idx_reg == AW'(n_reg - 1'b1));
                        if (idx_reg == AW'(n_reg - 1'b1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `DRN_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, out_valid, busy || out_data.last_return,
        "result word while block idle")
    `DRN_ASSERT_IMPL(a_last_ends, clk, rst_n, out_valid && out_data.last_return, !busy,
        "block still busy at final result")
    `DRN_ASSERT_NEXT(a_more_follow, clk, rst_n, out_valid && !out_data.last_return, busy,
        "block went idle before final result")
    `DRN_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(EPISODE_DEPTH),
        "step count beyond depth")
endmodule

// ===== design/drn_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module drn_divider #(
    parameter int unsigned NumWidth = 64,
    parameter int unsigned DenWidth = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NumWidth-1:0] num,
    input  logic [DenWidth-1:0] den,
    output logic                done,
    output logic [NumWidth-1:0] quot,
    output logic [DenWidth-1:0] rem
);
    localparam int unsigned CntWidth = $clog2(NumWidth + 1);
    logic [NumWidth-1:0] q_reg;
    logic [DenWidth:0]   r_reg;
    logic [DenWidth-1:0] d_reg;
    logic [CntWidth-1:0] cnt_reg;
    logic                run_reg;
    logic                done_reg;
    logic [DenWidth:0]   trial;

    // Shift in next numerator bit
    assign trial = {r_reg[DenWidth-1:0], q_reg[NumWidth-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CntWidth'(NumWidth);
                q_reg   <= num;
                r_reg   <= '0;
                d_reg   <= den;
            end
            else if (run_reg)
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[NumWidth-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NumWidth-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntWidth'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[DenWidth-1:0];
endmodule

// ===== design/drn_store.sv =====
// Reward and return memories, one synchronous read port each.
module drn_store (
    input  logic                           clk,
    input  logic                           rew_we,
    input  logic [drn_pkg::AddrWidth-1:0]  rew_waddr,
    input  logic signed [31:0]             rew_wdata,
    input  logic [drn_pkg::AddrWidth-1:0]  rew_raddr,
    output logic signed [31:0]             rew_rdata,
    input  logic                           ret_we,
    input  logic [drn_pkg::AddrWidth-1:0]  ret_waddr,
    input  logic signed [47:0]             ret_wdata,
    input  logic [drn_pkg::AddrWidth-1:0]  ret_raddr,
    output logic signed [47:0]             ret_rdata
);
    logic signed [31:0] rew_mem [drn_pkg::MaxDepth];
    logic signed [47:0] ret_mem [drn_pkg::MaxDepth];

    // Write and registered read of both memories
    always_ff @(posedge clk)
    begin
        if (rew_we)
        begin
            rew_mem[rew_waddr] <= rew_wdata;
        end
        if (ret_we)
        begin
            ret_mem[ret_waddr] <= ret_wdata;
        end
        rew_rdata <= rew_mem[rew_raddr];
        ret_rdata <= ret_mem[ret_raddr];
    end
endmodule
